[rtl/psth_pkg.sv]
// Shared constants, codes and pipeline context types for the penalized
// shrinkage threshold block. No dependencies.
package psth_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    // restoring divider: one input stage plus one quotient bit per stage
    localparam int DIV_STEPS = 32;
    localparam int DIV_LAT   = DIV_STEPS + 1;
    // context delay between front stage 3 and the first divider output
    localparam int CTX1_LEN  = DIV_LAT - 2;

    localparam logic [1:0] MODE_SOFT = 2'd0;
    localparam logic [1:0] MODE_MCP  = 2'd1;
    localparam logic [1:0] MODE_SCAD = 2'd2;

    localparam logic [1:0] REGION_ZERO = 2'd0;
    localparam logic [1:0] REGION_SOFT = 2'd1;
    localparam logic [1:0] REGION_MID  = 2'd2;
    localparam logic [1:0] REGION_PASS = 2'd3;

    localparam logic CFG_PENALTY_MODE = 1'b0;
    localparam logic CFG_GAMMA_SHAPE  = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        neg;
        logic [31:0] mag_in;
        logic [30:0] l1;
        logic [30:0] l2;
        logic [1:0]  mode;
        logic        zero;
        logic        in_bound;
        logic        le_mid;
    } t_ctx;

    typedef struct packed {
        logic       valid;
        logic       neg;
        logic [1:0] region;
        logic       force_zero;
    } t_tail;

endpackage

[rtl/psth_if.sv]
// Valid/ready channel interfaces for item input and result output.
// Depends on nothing but plain logic types.
interface psth_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_in;
    logic [30:0] thresh_one;
    logic [30:0] ridge_two;
    modport source (output valid, value_in, thresh_one, ridge_two, input ready);
    modport sink   (input valid, value_in, thresh_one, ridge_two, output ready);
endinterface

interface psth_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] shrunk_value;
    logic [1:0]  region;
    logic        saturated;
    modport source (output valid, shrunk_value, region, saturated, input ready);
    modport sink   (input valid, shrunk_value, region, saturated, output ready);
endinterface

[rtl/psth_div.sv]
// Pipelined restoring divider, one quotient bit per stage, 32-bit quotient
// with overflow flag. Depends on psth_pkg.
module psth_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic [31:0] o_quo,
    output logic        o_ovf
);
    import psth_pkg::*;

    logic [31:0] r_rem [0:DIV_STEPS];
    logic [31:0] r_low [0:DIV_STEPS];
    logic [31:0] r_quo [0:DIV_STEPS];
    logic [31:0] r_den [0:DIV_STEPS];
    logic        r_ovf [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num[63:32];
            r_low[0] <= i_num[31:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            // quotient will not fit in 32 bits
            r_ovf[0] <= (i_num[63:32] >= i_den);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [32:0] n_trial;
        logic        n_ge;
        always_comb begin
            n_trial = {r_rem[k], r_low[k][31]};
            n_ge    = (n_trial >= {1'b0, r_den[k]});
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_ge ? 32'(n_trial - {1'b0, r_den[k]}) : n_trial[31:0];
                r_low[k+1] <= {r_low[k][30:0], 1'b0};
                r_quo[k+1] <= {r_quo[k][30:0], n_ge};
                r_den[k+1] <= r_den[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS];
    assign o_ovf = r_ovf[DIV_STEPS];

endmodule

[rtl/penalized_shrink_threshold.sv]
// Penalized shrinkage operator (soft / MCP / SCAD) top level.
// Depends on psth_pkg, psth_if (channel interfaces) and psth_div.
//
// Usage:
//   i_item carries z, l1 and l2 (signed / nonnegative Q16.16); o_result
//   carries the shrunk value, the region code and a saturation flag. A
//   transfer happens when valid and ready are both high.
//   Config: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 penalty mode, 1 gamma); write only while no item is in flight.
//   Throughput: one item per cycle while the output is not stalled. Pipeline:
//   capture and gamma*l1 stages, a 33-stage divider
//   for the SCAD knee and 1/gamma (bound and midpoint products and the
//   compares run beside it), one operand-select stage, a second 33-stage
//   divider for the quotient and the output register.
//   The whole pipeline advances together when the output register is empty
//   or being taken; a stalled receiver freezes it with nothing lost, and the
//   input accepts again as soon as the result moves.
//   Reset: pipeline empty, mode soft, gamma 3.0.
module penalized_shrink_threshold (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [24:0]       i_cfg_data,
    psth_in_if.sink           i_item,
    psth_out_if.source        o_result
);
    import psth_pkg::*;

    logic        en;
    logic [1:0]  r_mode_cfg;
    logic [24:0] r_gamma_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_cfg  <= MODE_SOFT;
            r_gamma_cfg <= 25'd196608;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PENALTY_MODE: r_mode_cfg  <= i_cfg_data[1:0];
                CFG_GAMMA_SHAPE:  r_gamma_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: capture, magnitude, gamma clamp
    logic        n_neg0;
    logic [31:0] n_a0;
    logic [1:0]  n_mode0;
    logic [24:0] n_gmin0, n_g0;

    always_comb begin
        n_neg0  = i_item.value_in[31];
        n_a0    = n_neg0 ? 32'(-i_item.value_in) : i_item.value_in;
        n_mode0 = (r_mode_cfg == 2'd3) ? MODE_SOFT : r_mode_cfg;
        n_gmin0 = (n_mode0 == MODE_MCP) ? 25'(ONE + 32'd1) : 25'({ONE, 1'b0} + 33'd1);
        n_g0    = (r_gamma_cfg < n_gmin0) ? n_gmin0 : r_gamma_cfg;
    end

    logic        r_v0, r_neg0, r_zero0;
    logic [31:0] r_a0;
    logic [30:0] r_l10, r_l20;
    logic [1:0]  r_mode0;
    logic [24:0] r_g0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (en) r_v0 <= i_item.valid;
        if (en) begin
            r_neg0  <= n_neg0;
            r_a0    <= n_a0;
            r_l10   <= i_item.thresh_one;
            r_l20   <= i_item.ridge_two;
            r_mode0 <= n_mode0;
            r_g0    <= n_g0;
            r_zero0 <= (n_a0 <= {1'b0, i_item.thresh_one});
        end
    end

    // ---------------- stage 1: gamma * l1
    logic        r_v1, r_neg1, r_zero1;
    logic [31:0] r_a1;
    logic [30:0] r_l11, r_l21;
    logic [1:0]  r_mode1;
    logic [24:0] r_g1, r_gm1;
    logic [55:0] r_gl1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en) r_v1 <= r_v0;
        if (en) begin
            r_neg1  <= r_neg0;
            r_zero1 <= r_zero0;
            r_a1    <= r_a0;
            r_l11   <= r_l10;
            r_l21   <= r_l20;
            r_mode1 <= r_mode0;
            r_g1    <= r_g0;
            r_gm1   <= 25'(r_g0 - 25'(ONE));
            r_gl1   <= 56'(r_g0) * 56'(r_l10);
        end
    end

    // knee = gamma*l1/(gamma-1) and ig = ONE*ONE/(gamma or gamma-1)
    logic [31:0] knee_q, ig_q;
    logic        knee_ovf, ig_ovf;

    psth_div u_div_knee (
        .i_clk (i_clk), .i_en (en),
        .i_num (64'(r_gl1)), .i_den (32'(r_gm1)),
        .o_quo (knee_q), .o_ovf (knee_ovf)
    );

    psth_div u_div_ig (
        .i_clk (i_clk), .i_en (en),
        .i_num (64'(1) << (2 * FRAC_BITS)),
        .i_den ((r_mode1 == MODE_MCP) ? 32'(r_g1) : 32'(r_gm1)),
        .o_quo (ig_q), .o_ovf (ig_ovf)
    );

    // ---------------- stage 2: bound and midpoint products
    logic [39:0] gl_shift1;
    logic [31:0] opl2_1;
    assign gl_shift1 = r_gl1[55:FRAC_BITS];
    assign opl2_1    = ONE + 32'(r_l21);

    logic        r_v2, r_neg2, r_zero2, r_huge2;
    logic [31:0] r_a2;
    logic [30:0] r_l12, r_l22;
    logic [1:0]  r_mode2;
    logic [64:0] r_bprod2;
    logic [62:0] r_mprod2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (en) r_v2 <= r_v1;
        if (en) begin
            r_neg2   <= r_neg1;
            r_zero2  <= r_zero1;
            r_a2     <= r_a1;
            r_l12    <= r_l11;
            r_l22    <= r_l21;
            r_mode2  <= r_mode1;
            r_huge2  <= (|gl_shift1[39:33]) || (gl_shift1[32] && (|gl_shift1[31:0]));
            r_bprod2 <= 65'(gl_shift1[32:0]) * 65'(opl2_1);
            r_mprod2 <= 63'(r_l11) * 63'(opl2_1);
        end
    end

    // ---------------- stage 3: region compares
    logic [48:0] bound2;
    logic [47:0] mid2;
    assign bound2 = r_bprod2[64:FRAC_BITS];
    assign mid2   = 48'(r_mprod2[62:FRAC_BITS]) + 48'(r_l12);

    t_ctx r_ctx3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ctx3.valid <= 1'b0;
        else if (en) r_ctx3.valid <= r_v2;
        if (en) begin
            r_ctx3.neg      <= r_neg2;
            r_ctx3.mag_in   <= r_a2;
            r_ctx3.l1       <= r_l12;
            r_ctx3.l2       <= r_l22;
            r_ctx3.mode     <= r_mode2;
            r_ctx3.zero     <= r_zero2;
            r_ctx3.in_bound <= r_huge2 || (49'(r_a2) <= bound2);
            r_ctx3.le_mid   <= (48'(r_a2) <= mid2);
        end
    end

    t_ctx r_c1 [0:CTX1_LEN-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CTX1_LEN; k++) r_c1[k].valid <= 1'b0;
        end else if (en) begin
            r_c1[0] <= r_ctx3;
            for (int k = 1; k < CTX1_LEN; k++) r_c1[k] <= r_c1[k-1];
        end
    end

    // ---------------- operand select for the final quotient
    t_ctx        c1;
    logic [31:0] opl2_f, den_f, x_f;
    logic [1:0]  region_f;
    logic        fz_f;

    always_comb begin
        c1       = r_c1[CTX1_LEN-1];
        opl2_f   = ONE + 32'(c1.l2);
        x_f      = c1.mag_in - 32'(c1.l1);
        den_f    = opl2_f;
        region_f = REGION_SOFT;
        fz_f     = 1'b0;
        if (c1.zero) begin
            region_f = REGION_ZERO;
            fz_f     = 1'b1;
        end else begin
            case (c1.mode)
                MODE_MCP: begin
                    if (c1.in_bound) begin
                        den_f = opl2_f - ig_q;
                    end else begin
                        region_f = REGION_PASS;
                        x_f      = c1.mag_in;
                    end
                end
                MODE_SCAD: begin
                    if (c1.le_mid) begin
                        region_f = REGION_SOFT;
                    end else if (c1.in_bound) begin
                        region_f = REGION_MID;
                        den_f    = opl2_f - ig_q;
                        x_f      = c1.mag_in - knee_q;
                        // knee at or above |z| gives zero magnitude
                        fz_f     = knee_ovf || (knee_q >= c1.mag_in);
                    end else begin
                        region_f = REGION_PASS;
                        x_f      = c1.mag_in;
                    end
                end
                default: ;
            endcase
        end
    end

    logic [31:0] r_xf, r_denf;
    t_tail       r_tf;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tf.valid <= 1'b0;
        else if (en) r_tf.valid <= c1.valid;
        if (en) begin
            r_tf.neg        <= c1.neg;
            r_tf.region     <= region_f;
            r_tf.force_zero <= fz_f;
            r_xf            <= x_f;
            r_denf          <= den_f;
        end
    end

    logic [31:0] quo;
    logic        quo_ovf;

    psth_div u_div_main (
        .i_clk (i_clk), .i_en (en),
        .i_num (64'(r_xf) << FRAC_BITS), .i_den (r_denf),
        .o_quo (quo), .o_ovf (quo_ovf)
    );

    t_tail r_c2 [0:DIV_LAT-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) r_c2[k].valid <= 1'b0;
        end else if (en) begin
            r_c2[0] <= r_tf;
            for (int k = 1; k < DIV_LAT; k++) r_c2[k] <= r_c2[k-1];
        end
    end

    // ---------------- sign, saturation, output register
    t_tail       c2;
    logic [31:0] n_res;
    logic        n_sat;

    always_comb begin
        c2    = r_c2[DIV_LAT-1];
        n_sat = 1'b0;
        n_res = '0;
        if (!c2.force_zero) begin
            if (c2.neg) begin
                if (quo_ovf || quo > 32'h8000_0000) begin
                    n_sat = 1'b1;
                    n_res = 32'h8000_0000;
                end else begin
                    n_res = 32'(-quo);
                end
            end else begin
                if (quo_ovf || quo > 32'h7FFF_FFFF) begin
                    n_sat = 1'b1;
                    n_res = 32'h7FFF_FFFF;
                end else begin
                    n_res = quo;
                end
            end
        end
    end

    logic        r_ov, r_sat;
    logic [31:0] r_res;
    logic [1:0]  r_region;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (en) r_ov <= c2.valid;
        if (en) begin
            r_res    <= n_res;
            r_sat    <= n_sat;
            r_region <= c2.region;
        end
    end

    assign en                    = !r_ov || o_result.ready;
    assign i_item.ready          = en;
    assign o_result.valid        = r_ov;
    assign o_result.shrunk_value = r_res;
    assign o_result.region       = r_region;
    assign o_result.saturated    = r_sat;

    // ---------------- checks
    a_zero_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_region == REGION_ZERO |-> r_res == 32'd0 && !r_sat)
        else $error("zero region with nonzero result");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_sat |-> r_res == 32'h7FFF_FFFF || r_res == 32'h8000_0000)
        else $error("saturated result not at a range limit");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_c2[DIV_LAT-1].valid) && $stable(r_tf.valid))
        else $error("pipeline moved during stall");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && !r_c2[DIV_LAT-1].valid |=> !r_ov)
        else $error("result produced from empty slot");

    // clamped gamma keeps 1/gamma below one
    a_ig_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c1.valid |-> !ig_ovf)
        else $error("1/gamma quotient overflow");

endmodule
